@@ hw/rtl/stmd_pkg.sv @@
// Package with the shared types and constants of the scope trigger min/max decimator.
`timescale 1ns / 1ps

package stmd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int INDEX_W    = 12;
    localparam int TRIG_W     = 11;
    localparam int CFG_W      = 13;
    localparam int DIVIDEND_W = 25;
    localparam int REM_W      = 13;
    localparam int ACC_W      = 15;
    localparam int DISP_MIN   = 64;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    localparam logic REG_DISPLAY = 1'b0;
    localparam logic REG_COLUMNS = 1'b1;

    localparam logic [CFG_W-1:0] DISPLAY_RESET = 13'd441;
    localparam logic [CFG_W-1:0] COLUMNS_RESET = 13'd512;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_SETUP,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic query;
        logic div_init;
        logic div_step;
        logic scan_init;
        logic scan_step;
        logic result_load;
    } t_dp_cmd;

    typedef struct packed {
        logic ok;
        logic minmax;
        logic div_last;
        logic scan_last;
        logic out_busy;
    } t_dp_sts;

endpackage

@@ hw/rtl/stmd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module stmd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/stmd_regs.sv @@
// APB configuration registers for display length and column count.
`timescale 1ns / 1ps

module stmd_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [stmd_pkg::APB_AW-1:0]  i_paddr,
    input  logic [stmd_pkg::APB_DW-1:0]  i_pwdata,
    output logic [stmd_pkg::APB_DW-1:0]  o_prdata,
    output logic                         o_pready,
    output logic [stmd_pkg::CFG_W-1:0]   o_display,
    output logic [stmd_pkg::CFG_W-1:0]   o_columns
);

    import stmd_pkg::*;

    logic [CFG_W-1:0] r_display;
    logic [CFG_W-1:0] r_columns;
    logic             wr_en;
    logic             reg_sel;

    assign reg_sel = i_paddr[2];
    assign wr_en   = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_display <= DISPLAY_RESET;
            r_columns <= COLUMNS_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_DISPLAY: r_display <= i_pwdata[CFG_W-1:0];
                REG_COLUMNS: r_columns <= i_pwdata[CFG_W-1:0];
                default:     r_display <= r_display;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_DISPLAY: o_prdata = APB_DW'(r_display);
            REG_COLUMNS: o_prdata = APB_DW'(r_columns);
            default:     o_prdata = '0;
        endcase
    end

    assign o_pready  = 1'b1;
    assign o_display = r_display;
    assign o_columns = r_columns;

endmodule

@@ hw/rtl/stmd_ctrl.sv @@
// Controller state machine that sequences loads, column division, scan and result.
`timescale 1ns / 1ps

module stmd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_command,
    output logic              o_in_ready,
    input  stmd_pkg::t_dp_sts i_sts,
    output stmd_pkg::t_dp_cmd o_cmd
);

    import stmd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_command == CMD_QUERY) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!i_sts.ok) begin
                    n_state = ST_DONE;
                end else if (i_sts.minmax) begin
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_DONE;
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load    = i_in_valid && i_command == CMD_LOAD;
                o_cmd.query   = i_in_valid && i_command == CMD_QUERY;
            end
            ST_EVAL: begin
                o_cmd.div_init  = i_sts.ok && i_sts.minmax;
                o_cmd.scan_init = i_sts.ok && !i_sts.minmax;
            end
            ST_DIV:   o_cmd.div_step    = 1'b1;
            ST_SETUP: o_cmd.scan_init   = 1'b1;
            ST_SCAN:  o_cmd.scan_step   = 1'b1;
            ST_DRAIN: o_cmd             = '0;
            ST_DONE:  o_cmd.result_load = !i_sts.out_busy;
            default:  o_cmd             = '0;
        endcase
    end

endmodule

@@ hw/rtl/stmd_dp.sv @@
// Datapath: sample store, trigger search, column bound divider, min/max scan and output.
`timescale 1ns / 1ps

module stmd_dp #(
    parameter int MAX_WINDOW     = 8192,
    parameter int TRIGGER_SEARCH = 1024,
    parameter int MAX_COLUMNS    = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [stmd_pkg::CFG_W-1:0]          i_display,
    input  logic [stmd_pkg::CFG_W-1:0]          i_columns,
    input  stmd_pkg::t_dp_cmd                   i_cmd,
    output stmd_pkg::t_dp_sts                   o_sts,
    input  logic signed [stmd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_frame_start,
    input  logic [stmd_pkg::INDEX_W-1:0]        i_point_index,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_point_valid,
    output logic signed [stmd_pkg::SAMPLE_W-1:0] o_point_min,
    output logic signed [stmd_pkg::SAMPLE_W-1:0] o_point_max,
    output logic [stmd_pkg::TRIG_W-1:0]         o_trigger_index
);

    import stmd_pkg::*;

    localparam int AW  = $clog2(MAX_WINDOW);
    localparam int CW  = $clog2(MAX_WINDOW + 1);
    localparam int DCW = $clog2(DIVIDEND_W);
    localparam int SW  = AW + 14;
    localparam int TW  = AW + TRIG_W;
    localparam int DISP_MAX = (MAX_WINDOW > TRIGGER_SEARCH + DISP_MIN) ?
                              (MAX_WINDOW - TRIGGER_SEARCH) : DISP_MIN;

    logic [CFG_W-1:0] disp_eff;
    logic [CFG_W-1:0] cols_eff;
    int               flen_i;
    int               search_end_i;

    logic [CW-1:0]           r_lc;
    logic [AW-1:0]           r_trig;
    logic                    r_found;
    logic signed [SAMPLE_W-1:0] r_prev;

    logic [CW-1:0] pos;
    logic          lc_full;
    logic          wr_en;
    logic          trig_hit;

    logic [DIVIDEND_W-1:0] prod;
    logic                  frame_ok;
    logic                  idx_ok;
    logic                  mode_minmax;

    logic [INDEX_W-1:0]    r_idx;
    logic                  r_ok;
    logic                  r_minmax;
    logic [DIVIDEND_W-1:0] r_prod;
    logic [DIVIDEND_W-1:0] r_div;
    logic [REM_W-1:0]      r_rem;
    logic [DCW-1:0]        r_cnt;
    logic [REM_W:0]        rem_sh;
    logic                  q_bit;

    logic [AW-1:0]             r_addr;
    logic [ACC_W-1:0]          r_acc;
    logic                      r_single;
    logic                      r_pend;
    logic signed [SAMPLE_W-1:0] r_min;
    logic signed [SAMPLE_W-1:0] r_max;
    logic [SW-1:0]             addr_sum;
    logic                      scan_last;
    logic signed [SAMPLE_W-1:0] rdata;

    logic                      r_out_valid;
    logic                      r_point_valid;
    logic signed [SAMPLE_W-1:0] r_point_min;
    logic signed [SAMPLE_W-1:0] r_point_max;
    logic [TRIG_W-1:0]         r_trigger_index;
    logic [TW-1:0]             trig_ext;

    always_comb begin
        if (int'(i_display) < DISP_MIN) begin
            disp_eff = CFG_W'(DISP_MIN);
        end else if (int'(i_display) > DISP_MAX) begin
            disp_eff = CFG_W'(DISP_MAX);
        end else begin
            disp_eff = i_display;
        end
        if (i_columns == '0) begin
            cols_eff = CFG_W'(1);
        end else if (int'(i_columns) > MAX_COLUMNS) begin
            cols_eff = CFG_W'(MAX_COLUMNS);
        end else begin
            cols_eff = i_columns;
        end
        flen_i = int'(disp_eff) + TRIGGER_SEARCH;
        if (flen_i > MAX_WINDOW) begin
            flen_i = MAX_WINDOW;
        end
        search_end_i = flen_i - int'(disp_eff);
    end

    // Frame loading and rising zero crossing search.
    assign lc_full  = int'(r_lc) >= flen_i;
    assign wr_en    = i_cmd.load && (i_frame_start || !lc_full);
    assign pos      = i_frame_start ? '0 : r_lc;
    assign trig_hit = !i_frame_start && !r_found && pos != '0 &&
                      int'(pos) <= search_end_i && r_prev[SAMPLE_W-1] &&
                      !i_sample[SAMPLE_W-1];

    // Query checks.
    assign prod        = DIVIDEND_W'(i_point_index) * DIVIDEND_W'(disp_eff);
    assign frame_ok    = lc_full && (int'(r_trig) + int'(disp_eff) <= int'(r_lc));
    assign mode_minmax = disp_eff > cols_eff;
    assign idx_ok      = mode_minmax ? (CFG_W'(i_point_index) < cols_eff) :
                                       (CFG_W'(i_point_index) < disp_eff);

    // Restoring division step for the column start.
    assign rem_sh = {r_rem, r_div[DIVIDEND_W-1]};
    assign q_bit  = rem_sh >= (REM_W + 1)'(cols_eff);

    assign addr_sum  = r_minmax ? (SW'(r_trig) + SW'(r_div[CFG_W-1:0])) :
                                  (SW'(r_trig) + SW'(r_idx));
    assign scan_last = r_single || (r_acc < ACC_W'(cols_eff));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lc        <= '0;
            r_trig      <= '0;
            r_found     <= 1'b0;
            r_prev      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_prev <= i_sample;
                r_lc   <= pos + CW'(1);
                if (i_frame_start) begin
                    r_trig  <= '0;
                    r_found <= 1'b0;
                end else if (trig_hit) begin
                    r_trig  <= pos[AW-1:0];
                    r_found <= 1'b1;
                end
            end
            r_pend <= i_cmd.scan_step;
            if (i_cmd.result_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.query) begin
            r_idx    <= i_point_index;
            r_ok     <= frame_ok && idx_ok;
            r_minmax <= mode_minmax;
            r_prod   <= prod;
        end
        if (i_cmd.div_init) begin
            r_div <= r_prod;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div <= {r_div[DIVIDEND_W-2:0], q_bit};
            r_rem <= q_bit ? REM_W'(rem_sh - (REM_W + 1)'(cols_eff)) : rem_sh[REM_W-1:0];
            r_cnt <= r_cnt + DCW'(1);
        end
        if (i_cmd.scan_init) begin
            r_addr   <= addr_sum[AW-1:0];
            r_acc    <= ACC_W'(r_rem) + ACC_W'(disp_eff) - ACC_W'(cols_eff);
            r_single <= !r_minmax;
            r_min    <= SAMPLE_MAX;
            r_max    <= SAMPLE_MIN;
        end else begin
            if (i_cmd.scan_step) begin
                r_addr <= r_addr + AW'(1);
                r_acc  <= r_acc - ACC_W'(cols_eff);
            end
            if (r_pend) begin
                if (rdata < r_min) begin
                    r_min <= rdata;
                end
                if (rdata > r_max) begin
                    r_max <= rdata;
                end
            end
        end
        if (i_cmd.result_load) begin
            r_point_valid   <= r_ok;
            r_point_min     <= r_ok ? r_min : '0;
            r_point_max     <= r_ok ? r_max : '0;
            r_trigger_index <= r_ok ? trig_ext[TRIG_W-1:0] : '0;
        end
    end

    assign trig_ext = TW'(r_trig);

    stmd_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(MAX_WINDOW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_waddr(pos[AW-1:0]),
        .i_wdata(i_sample),
        .i_re   (i_cmd.scan_step),
        .i_raddr(r_addr),
        .o_rdata(rdata)
    );

    assign o_sts.ok        = r_ok;
    assign o_sts.minmax    = r_minmax;
    assign o_sts.div_last  = r_cnt == DCW'(DIVIDEND_W - 1);
    assign o_sts.scan_last = scan_last;
    assign o_sts.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_point_valid   = r_point_valid;
    assign o_point_min     = r_point_min;
    assign o_point_max     = r_point_max;
    assign o_trigger_index = r_trigger_index;

endmodule

@@ hw/rtl/scope_trigger_minmax_decimator_top.sv @@
// Top level of the scope trigger min/max decimator.
//
// Channel   Direction  Contents
// s_axis    in         tuser command, tdata sample / frame_start / point_index
// m_axis    out        tuser point_valid, tdata point_min / point_max / trigger_index
// apb       in/out     display_samples at 0x0, columns at 0x4
//
// Loads stream samples in at one item per cycle while no query is in progress.
// A sample-mode query runs the eval, scan, drain and done states; a rejected
// query goes from eval to done. A min/max query runs the bit-serial divider for the
// column start, then scans the column through the single read port of the store.
// Reset clears the frame count and trigger; the sample store is not cleared.
// A finished result waits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps

module scope_trigger_minmax_decimator_top #(
    parameter int MAX_WINDOW     = 8192,
    parameter int TRIGGER_SEARCH = 1024,
    parameter int MAX_COLUMNS    = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [15:0] sample, [16] frame_start, [28:17] point_index, [31:29] zero
    input  logic [stmd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [0] command
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [15:0] point_min, [31:16] point_max, [42:32] trigger_index, [47:43] zero
    output logic [stmd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [0] point_valid
    output logic                           m_axis_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [stmd_pkg::APB_AW-1:0]    paddr,
    input  logic [stmd_pkg::APB_DW-1:0]    pwdata,
    output logic [stmd_pkg::APB_DW-1:0]    prdata,
    output logic                           pready
);

    import stmd_pkg::*;

    logic [CFG_W-1:0]           display;
    logic [CFG_W-1:0]           columns;
    t_dp_cmd                    cmd;
    t_dp_sts                    sts;
    logic signed [SAMPLE_W-1:0] point_min;
    logic signed [SAMPLE_W-1:0] point_max;
    logic [TRIG_W-1:0]          trigger_index;

    stmd_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_psel   (psel),
        .i_penable(penable),
        .i_pwrite (pwrite),
        .i_paddr  (paddr),
        .i_pwdata (pwdata),
        .o_prdata (prdata),
        .o_pready (pready),
        .o_display(display),
        .o_columns(columns)
    );

    stmd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(s_axis_tvalid),
        .i_command (s_axis_tuser),
        .o_in_ready(s_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    stmd_dp #(
        .MAX_WINDOW    (MAX_WINDOW),
        .TRIGGER_SEARCH(TRIGGER_SEARCH),
        .MAX_COLUMNS   (MAX_COLUMNS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_display      (display),
        .i_columns      (columns),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_sample       (s_axis_tdata[15:0]),
        .i_frame_start  (s_axis_tdata[16]),
        .i_point_index  (s_axis_tdata[28:17]),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_point_valid  (m_axis_tuser),
        .o_point_min    (point_min),
        .o_point_max    (point_max),
        .o_trigger_index(trigger_index)
    );

    assign m_axis_tdata = {5'b0, trigger_index, point_max, point_min};

endmodule
